>>> design/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for coning / sculling compensation
// Command and status types between the controller and the datapath, the
// coning coefficient table and the fixed-point shift amounts.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Group length register
  localparam int unsigned CFG_W           = 3;
  localparam int unsigned CSC_MAX_SAMPLES = 5;

  // Coning coefficients, unsigned Q16
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned COEF_ROWS = 5;
  localparam logic [COEF_W-1:0] CSC_COEF [COEF_ROWS][4] = '{
    '{18'd0,     18'd0,     18'd0,      18'd0},
    '{18'd43691, 18'd0,     18'd0,      18'd0},
    '{18'd29491, 18'd88474, 18'd0,      18'd0},
    '{18'd33704, 18'd57422, 18'd133569, 18'd0},
    '{18'd32508, 18'd68267, 18'd84521,  18'd178794}
  };

  // Fixed-point shifts
  localparam int unsigned CS_SH  = 11;  // coefficient product to cone/scull LSB
  localparam int unsigned OUT_SH = 35;  // result accumulator to output LSB
  localparam int unsigned TW_SH  = 27;  // one-twelfth term: shift before divide by 3
  localparam int unsigned DV_SH  = 4;   // half wsum x vsum alignment

  // Multiplier A operand source
  typedef enum logic [2:0] {
    AS_COEF,
    AS_PG,
    AS_PV,
    AS_CONE,
    AS_SCULL,
    AS_WSUM
  } csc_asel_e;

  // Multiplier B operand source
  typedef enum logic [1:0] {
    BS_G,
    BS_V,
    BS_VSUM
  } csc_bsel_e;

  // Accumulator preload
  typedef enum logic [1:0] {
    PL_NONE,
    PL_ZERO,
    PL_WSUM,
    PL_VSUM
  } csc_pre_e;

  // Accumulator commit target
  typedef enum logic [2:0] {
    CM_NONE,
    CM_CS_CONE,
    CM_CS_SCULL,
    CM_TW_CONE,
    CM_TW_SCULL,
    CM_ROT,
    CM_DV
  } csc_commit_e;

  typedef struct packed {
    logic              load;
    logic              sum_add;
    logic              prev_load;
    logic              sum_clear;
    csc_pre_e          pre;
    logic              mul_en;
    csc_asel_e         asel;
    csc_bsel_e         bsel;
    logic [1:0]        ai;
    logic [1:0]        bi;
    logic              neg;
    logic              hi;
    logic              sh4;
    logic              div_start;
    csc_commit_e       commit;
    logic [1:0]        k;
    logic [COEF_W-1:0] coef;
  } csc_cmd_t;

  typedef struct packed {
    logic div_busy;
  } csc_stat_t;

  // Coefficient for group length n (1..5) and sample position i
  function automatic logic [COEF_W-1:0] csc_coef(input logic [CFG_W-1:0] n,
                                                  input logic [1:0] i);
    logic [CFG_W-1:0] r;
    r = n - CFG_W'(1);
    if (r < CFG_W'(COEF_ROWS)) begin
      csc_coef = CSC_COEF[r][i];
    end else begin
      csc_coef = '0;
    end
  endfunction

endpackage

>>> design/csc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_in_if: IMU sample channel
// Valid/ready channel carrying one gyro and one velocity increment triple.
// ----------------------------------------------------------------------------
interface csc_in_if #(
  parameter int unsigned SW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] gyro_x;
  logic signed [SW-1:0] gyro_y;
  logic signed [SW-1:0] gyro_z;
  logic signed [SW-1:0] vel_x;
  logic signed [SW-1:0] vel_y;
  logic signed [SW-1:0] vel_z;

  modport source (output valid, gyro_x, gyro_y, gyro_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, gyro_x, gyro_y, gyro_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

>>> design/csc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_out_if: compensated result channel
// Valid/ready channel carrying the rotation vector and velocity increment.
// ----------------------------------------------------------------------------
interface csc_out_if #(
  parameter int unsigned SW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] rot_x;
  logic signed [SW-1:0] rot_y;
  logic signed [SW-1:0] rot_z;
  logic signed [SW-1:0] dv_x;
  logic signed [SW-1:0] dv_y;
  logic signed [SW-1:0] dv_z;

  modport source (output valid, rot_x, rot_y, rot_z, dv_x, dv_y, dv_z,
                  input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, dv_x, dv_y, dv_z,
                  output ready);
endinterface

>>> design/csc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_cfg_if: configuration write channel
// Valid/ready channel carrying the samples-per-group register value.
// ----------------------------------------------------------------------------
interface csc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/csc_div3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_div3: divide by three, one ten-bit digit per cycle
// Floor division of an unsigned word by 3. Each cycle takes the next ten-bit
// digit with the running remainder and finds its quotient digit through a
// small reciprocal multiply.
// ----------------------------------------------------------------------------
module csc_div3 #(
  parameter int unsigned U_W = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [U_W-1:0] dividend_i,
  output logic           busy_o,
  output logic [U_W-1:0] quot_o
);
  localparam int unsigned CH_W   = 10;
  localparam int unsigned N_CH   = (U_W + CH_W - 1) / CH_W;
  localparam int unsigned PAD_W  = N_CH * CH_W;
  localparam int unsigned CNT_W  = $clog2(N_CH + 1);
  localparam int unsigned CUR_W  = CH_W + 2;
  localparam int unsigned RCP_SH = 13;
  localparam int unsigned PRD_W  = RCP_SH + CH_W;
  // ceil(2^13 / 3): exact floor for any partial dividend below 3 * 2^10
  localparam logic [CUR_W-1:0] RECIP = CUR_W'(2731);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       rem_q, rem_d;
  logic [PAD_W-1:0] sh_q;
  logic [CUR_W-1:0] cur;
  logic [PRD_W-1:0] prod;
  logic [CH_W-1:0]  digit;

  // One digit step: remainder and next digit over three
  always_comb begin
    cur   = {rem_q, sh_q[PAD_W-1 -: CH_W]};
    prod  = PRD_W'(cur) * PRD_W'(RECIP);
    digit = prod[RCP_SH +: CH_W];
    rem_d = 2'(cur - CUR_W'(digit) * CUR_W'(3));
  end

  // Control: count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(N_CH);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift dividend digits out, quotient digits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PAD_W'(dividend_i);
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= (sh_q << CH_W) | PAD_W'(digit);
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q[U_W-1:0];

endmodule

>>> design/csc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_datapath: sums, shared multiplier and result accumulator
// Holds the sample, running sums, cone/scull sums and previous sample.
// A split multiplier feeds one accumulator; commits round and saturate it.
// ----------------------------------------------------------------------------
module csc_datapath
  import csc_pkg::*;
#(
  parameter int unsigned SW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csc_cmd_t             cmd_i,
  output csc_stat_t            stat_o,
  input  logic signed [SW-1:0] gyro_x_i,
  input  logic signed [SW-1:0] gyro_y_i,
  input  logic signed [SW-1:0] gyro_z_i,
  input  logic signed [SW-1:0] vel_x_i,
  input  logic signed [SW-1:0] vel_y_i,
  input  logic signed [SW-1:0] vel_z_i,
  output logic signed [SW-1:0] rot_x_o,
  output logic signed [SW-1:0] rot_y_o,
  output logic signed [SW-1:0] rot_z_o,
  output logic signed [SW-1:0] dv_x_o,
  output logic signed [SW-1:0] dv_y_o,
  output logic signed [SW-1:0] dv_z_o
);
  localparam int unsigned SUM_W = SW + 3;
  localparam int unsigned CS_W  = SW + 8;
  localparam int unsigned LO_W  = CS_W / 2;
  localparam int unsigned HI_W  = CS_W - LO_W;
  localparam int unsigned P_W   = HI_W + 1;
  localparam int unsigned PR_W  = P_W + SUM_W;
  localparam int unsigned ACC_W = (2 * SUM_W + 8 > SUM_W + 38) ? 2 * SUM_W + 8
                                                               : SUM_W + 38;
  localparam int unsigned KB    = 2 * SW - 26;
  localparam int unsigned U_W   = KB + 2;

  function automatic logic signed [CS_W-1:0] sat_cs(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] mx, mn;
    mx = {{(ACC_W - CS_W + 1){1'b0}}, {(CS_W - 1){1'b1}}};
    mn = ~mx;
    if (x > mx) sat_cs = mx[CS_W-1:0];
    else if (x < mn) sat_cs = mn[CS_W-1:0];
    else sat_cs = x[CS_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] mx, mn;
    mx = {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
    mn = ~mx;
    if (x > mx) sat_sum = mx[SUM_W-1:0];
    else if (x < mn) sat_sum = mn[SUM_W-1:0];
    else sat_sum = x[SUM_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_out(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] mx, mn;
    mx = {{(ACC_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    mn = ~mx;
    if (x > mx) sat_out = mx[SW-1:0];
    else if (x < mn) sat_out = mn[SW-1:0];
    else sat_out = x[SW-1:0];
  endfunction

  logic signed [SW-1:0]    in_g [3];
  logic signed [SW-1:0]    in_v [3];
  logic signed [SW-1:0]    g_q [3];
  logic signed [SW-1:0]    v_q [3];
  logic signed [SW-1:0]    pg_q [3];
  logic signed [SW-1:0]    pv_q [3];
  logic signed [SW-1:0]    rot_q [3];
  logic signed [SW-1:0]    dv_q [3];
  logic signed [SUM_W-1:0] ws_q [3];
  logic signed [SUM_W-1:0] vs_q [3];
  logic signed [CS_W-1:0]  cone_q [3];
  logic signed [CS_W-1:0]  scull_q [3];

  logic signed [CS_W-1:0]  a_full;
  logic signed [SUM_W-1:0] b_full;
  logic signed [P_W-1:0]   a_part;
  logic signed [PR_W-1:0]  prod_d, prod_q;
  logic                    add_q, neg_q, hi_q, sh4_q;
  logic signed [ACC_W-1:0] term_ext, term_hi, term_sh, acc_add, acc_q;

  logic signed [ACC_W-1:0] cs_rnd, out_rnd, tw_a, quot_ext, tw_full, cs_sum;
  logic signed [CS_W-1:0]  cs_t, tw_t, add_t, cs_base, cs_new;
  logic signed [SW-1:0]    out_t;
  logic [U_W-1:0]          div_in, quot;
  logic                    div_busy;

  assign in_g[0] = gyro_x_i;
  assign in_g[1] = gyro_y_i;
  assign in_g[2] = gyro_z_i;
  assign in_v[0] = vel_x_i;
  assign in_v[1] = vel_y_i;
  assign in_v[2] = vel_z_i;

  // Operand select and partial product (low or high half of A)
  always_comb begin
    unique case (cmd_i.asel)
      AS_COEF:  a_full = signed'({{(CS_W - COEF_W){1'b0}}, cmd_i.coef});
      AS_PG:    a_full = CS_W'(pg_q[cmd_i.ai]);
      AS_PV:    a_full = CS_W'(pv_q[cmd_i.ai]);
      AS_CONE:  a_full = cone_q[cmd_i.ai];
      AS_SCULL: a_full = scull_q[cmd_i.ai];
      AS_WSUM:  a_full = CS_W'(ws_q[cmd_i.ai]);
      default:  a_full = '0;
    endcase
    unique case (cmd_i.bsel)
      BS_G:    b_full = SUM_W'(g_q[cmd_i.bi]);
      BS_V:    b_full = SUM_W'(v_q[cmd_i.bi]);
      BS_VSUM: b_full = vs_q[cmd_i.bi];
      default: b_full = '0;
    endcase
    if (cmd_i.hi) begin
      a_part = P_W'(signed'(a_full[CS_W-1:LO_W]));
    end else begin
      a_part = signed'(P_W'(a_full[LO_W-1:0]));
    end
    prod_d = a_part * b_full;
  end

  // Align the registered product for accumulation
  always_comb begin
    term_ext = ACC_W'(prod_q);
    term_hi  = hi_q ? (term_ext <<< LO_W) : term_ext;
    term_sh  = sh4_q ? (term_hi <<< DV_SH) : term_hi;
    acc_add  = neg_q ? (acc_q - term_sh) : (acc_q + term_sh);
  end

  // Product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
    end else begin
      add_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= cmd_i.neg;
    hi_q   <= cmd_i.hi;
    sh4_q  <= cmd_i.sh4;
  end

  // Accumulator: preload, add or subtract
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.pre)
      PL_ZERO: acc_q <= '0;
      PL_WSUM: acc_q <= ACC_W'(ws_q[cmd_i.k]) <<< OUT_SH;
      PL_VSUM: acc_q <= ACC_W'(vs_q[cmd_i.k]) <<< OUT_SH;
      PL_NONE: begin
        if (add_q) acc_q <= acc_add;
      end
      default: acc_q <= acc_q;
    endcase
  end

  // Rounding of the accumulator for each commit kind
  always_comb begin
    cs_rnd   = (acc_q + (ACC_W'(1) <<< (CS_SH - 1))) >>> CS_SH;
    cs_t     = sat_cs(cs_rnd);
    out_rnd  = (acc_q + (ACC_W'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
    out_t    = sat_out(out_rnd);
    tw_a     = (acc_q + (ACC_W'(3) <<< (TW_SH - 1))) >>> TW_SH;
    div_in   = U_W'(signed'(tw_a[KB:0])) + (U_W'(3) << KB);
    quot_ext = ACC_W'(quot);
    tw_full  = quot_ext - (ACC_W'(1) <<< KB);
    tw_t     = sat_cs(tw_full);
    if (cmd_i.commit == CM_TW_CONE || cmd_i.commit == CM_TW_SCULL) begin
      add_t = tw_t;
    end else begin
      add_t = cs_t;
    end
    if (cmd_i.commit == CM_CS_CONE || cmd_i.commit == CM_TW_CONE) begin
      cs_base = cone_q[cmd_i.k];
    end else begin
      cs_base = scull_q[cmd_i.k];
    end
    cs_sum = ACC_W'(cs_base) + ACC_W'(add_t);
    cs_new = sat_cs(cs_sum);
  end

  csc_div3 #(
    .U_W(U_W)
  ) u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_in),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign stat_o.div_busy = div_busy;

  // Sample register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        g_q[i] <= in_g[i];
        v_q[i] <= in_v[i];
      end
    end
  end

  // Running sums, cone/scull sums and previous sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ws_q[i]    <= '0;
        vs_q[i]    <= '0;
        cone_q[i]  <= '0;
        scull_q[i] <= '0;
        pg_q[i]    <= '0;
        pv_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.sum_add) begin
        for (int i = 0; i < 3; i++) begin
          ws_q[i] <= sat_sum(ACC_W'(ws_q[i]) + ACC_W'(g_q[i]));
          vs_q[i] <= sat_sum(ACC_W'(vs_q[i]) + ACC_W'(v_q[i]));
        end
      end
      if (cmd_i.sum_clear) begin
        for (int i = 0; i < 3; i++) begin
          ws_q[i]    <= '0;
          vs_q[i]    <= '0;
          cone_q[i]  <= '0;
          scull_q[i] <= '0;
        end
      end
      if (cmd_i.prev_load) begin
        for (int i = 0; i < 3; i++) begin
          pg_q[i] <= g_q[i];
          pv_q[i] <= v_q[i];
        end
      end
      if (cmd_i.commit == CM_CS_CONE || cmd_i.commit == CM_TW_CONE) begin
        cone_q[cmd_i.k] <= cs_new;
      end
      if (cmd_i.commit == CM_CS_SCULL || cmd_i.commit == CM_TW_SCULL) begin
        scull_q[cmd_i.k] <= cs_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit == CM_ROT) rot_q[cmd_i.k] <= out_t;
    if (cmd_i.commit == CM_DV) dv_q[cmd_i.k] <= out_t;
  end

  assign rot_x_o = rot_q[0];
  assign rot_y_o = rot_q[1];
  assign rot_z_o = rot_q[2];
  assign dv_x_o  = dv_q[0];
  assign dv_y_o  = dv_q[1];
  assign dv_z_o  = dv_q[2];

endmodule

>>> design/csc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ctrl: compensation sequencer
// Tracks the group position and steps the datapath through the product
// jobs of one sample: coefficient terms, one-sample cone/scull terms and
// the six result components.
// ----------------------------------------------------------------------------
module csc_ctrl
  import csc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_valid_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  csc_stat_t        stat_i,
  output csc_cmd_t         cmd_o
);
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_JOB,
    ST_MUL,
    ST_DRAIN,
    ST_COMMIT,
    ST_DIV,
    ST_TWC,
    ST_PREV,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    JB_COEF_G,
    JB_COEF_V,
    JB_TC,
    JB_TS,
    JB_ROT,
    JB_DV
  } job_e;

  state_e           state_q;
  job_e             job_q;
  logic [1:0]       k_q, pair_q;
  logic             term_q, half_q;
  logic [CFG_W-1:0] idx_q, spg_q, n_eff;
  logic             first_q, last_q, one_q, out_valid_q;
  logic             single, last_pair, prod_end, k_end;
  logic [1:0]       i1, i2;

  // Effective group length
  always_comb begin
    if (spg_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (spg_q > CFG_W'(CSC_MAX_SAMPLES)) begin
      n_eff = CFG_W'(CSC_MAX_SAMPLES);
    end else begin
      n_eff = spg_q;
    end
  end

  // Product bookkeeping within a job
  always_comb begin
    single = (job_q == JB_COEF_G) || (job_q == JB_COEF_V);
    unique case (job_q)
      JB_TS:   last_pair = (pair_q == 2'd1);
      JB_DV:   last_pair = (pair_q == 2'd2);
      default: last_pair = 1'b1;
    endcase
    prod_end = half_q && (single || term_q);
    k_end    = (k_q == 2'd2);
    i1       = (k_q == 2'd2) ? 2'd0 : 2'(k_q + 2'd1);
    i2       = (k_q == 2'd0) ? 2'd2 : 2'(k_q - 2'd1);
  end

  // Datapath commands from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.pre       = PL_NONE;
    cmd_o.commit    = CM_NONE;
    cmd_o.asel      = AS_COEF;
    cmd_o.bsel      = BS_G;
    cmd_o.k         = k_q;
    cmd_o.coef      = csc_coef(n_eff, idx_q[1:0]);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sum_add   = (state_q == ST_SUM);
    cmd_o.prev_load = ((state_q == ST_SUM) && last_q && one_q && first_q)
                      || (state_q == ST_PREV);
    cmd_o.sum_clear = (state_q == ST_DONE);
    cmd_o.div_start = (state_q == ST_COMMIT)
                      && ((job_q == JB_TC) || (job_q == JB_TS));
    if (state_q == ST_JOB) begin
      unique case (job_q)
        JB_ROT:  cmd_o.pre = PL_WSUM;
        JB_DV:   cmd_o.pre = PL_VSUM;
        default: cmd_o.pre = PL_ZERO;
      endcase
    end
    if (state_q == ST_MUL) begin
      cmd_o.mul_en = 1'b1;
      cmd_o.hi     = half_q;
      unique case (job_q)
        JB_COEF_G: begin cmd_o.asel = AS_COEF;  cmd_o.bsel = BS_G; end
        JB_COEF_V: begin cmd_o.asel = AS_COEF;  cmd_o.bsel = BS_V; end
        JB_TC:     begin cmd_o.asel = AS_PG;    cmd_o.bsel = BS_G; end
        JB_TS: begin
          cmd_o.asel = (pair_q == 2'd0) ? AS_PG : AS_PV;
          cmd_o.bsel = (pair_q == 2'd0) ? BS_V : BS_G;
        end
        JB_ROT:    begin cmd_o.asel = AS_CONE;  cmd_o.bsel = BS_G; end
        JB_DV: begin
          unique case (pair_q)
            2'd0: begin
              cmd_o.asel = AS_WSUM;
              cmd_o.bsel = BS_VSUM;
              cmd_o.sh4  = 1'b1;
            end
            2'd1: begin cmd_o.asel = AS_CONE;  cmd_o.bsel = BS_V; end
            default: begin cmd_o.asel = AS_SCULL; cmd_o.bsel = BS_G; end
          endcase
        end
        default: begin cmd_o.asel = AS_COEF; cmd_o.bsel = BS_G; end
      endcase
      if (single) begin
        cmd_o.ai = k_q;
        cmd_o.bi = k_q;
      end else if (!term_q) begin
        cmd_o.ai = i1;
        cmd_o.bi = i2;
      end else begin
        cmd_o.ai  = i2;
        cmd_o.bi  = i1;
        cmd_o.neg = 1'b1;
      end
    end
    if (state_q == ST_COMMIT) begin
      unique case (job_q)
        JB_COEF_G: cmd_o.commit = CM_CS_CONE;
        JB_COEF_V: cmd_o.commit = CM_CS_SCULL;
        JB_ROT:    cmd_o.commit = CM_ROT;
        JB_DV:     cmd_o.commit = CM_DV;
        default:   cmd_o.commit = CM_NONE;
      endcase
    end
    if (state_q == ST_TWC) begin
      cmd_o.commit = (job_q == JB_TC) ? CM_TW_CONE : CM_TW_SCULL;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer state and registered status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JB_COEF_G;
      k_q         <= '0;
      pair_q      <= '0;
      term_q      <= 1'b0;
      half_q      <= 1'b0;
      idx_q       <= '0;
      spg_q       <= CFG_W'(2);
      first_q     <= 1'b1;
      last_q      <= 1'b0;
      one_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) spg_q <= cfg_data_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q  <= !(({1'b0, idx_q} + 4'd1) < {1'b0, n_eff});
            one_q   <= (n_eff == CFG_W'(1));
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          k_q <= '0;
          if (!last_q) begin
            job_q   <= JB_COEF_G;
            state_q <= ST_JOB;
          end else if (one_q) begin
            first_q <= 1'b0;
            job_q   <= JB_TC;
            state_q <= ST_JOB;
          end else begin
            first_q <= 1'b1;
            job_q   <= JB_ROT;
            state_q <= ST_WAIT;
          end
        end
        ST_JOB: begin
          pair_q  <= '0;
          term_q  <= 1'b0;
          half_q  <= 1'b0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          half_q <= !half_q;
          if (half_q) begin
            if (prod_end) begin
              term_q <= 1'b0;
              if (last_pair) begin
                state_q <= ST_DRAIN;
              end else begin
                pair_q <= pair_q + 2'd1;
              end
            end else begin
              term_q <= 1'b1;
            end
          end
        end
        ST_DRAIN: state_q <= ST_COMMIT;
        ST_DIV: begin
          if (!stat_i.div_busy) state_q <= ST_TWC;
        end
        ST_COMMIT, ST_TWC: begin
          if ((state_q == ST_COMMIT) && ((job_q == JB_TC) || (job_q == JB_TS))) begin
            state_q <= ST_DIV;
          end else if (!k_end) begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_JOB;
          end else begin
            k_q <= '0;
            unique case (job_q)
              JB_COEF_G: begin job_q <= JB_COEF_V; state_q <= ST_JOB; end
              JB_COEF_V: begin
                idx_q   <= idx_q + CFG_W'(1);
                first_q <= 1'b1;
                state_q <= ST_IDLE;
              end
              JB_TC:   begin job_q <= JB_TS; state_q <= ST_JOB; end
              JB_TS:   state_q <= ST_PREV;
              JB_ROT:  begin job_q <= JB_DV; state_q <= ST_JOB; end
              JB_DV:   state_q <= ST_DONE;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PREV: begin
          job_q   <= JB_ROT;
          k_q     <= '0;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!out_valid_q) state_q <= ST_JOB;
        end
        ST_DONE: begin
          idx_q       <= '0;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/coning_sculling_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coning_sculling_compensation: multi-sample coning and sculling correction
// Collects groups of IMU samples and returns the compensated rotation
// vector and velocity increment at the end of each group.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  gyro_x/y/z, vel_x/y/z
//   out_ch   out  valid/ready  rot_x/y/z, dv_x/y/z
//   cfg_ch   in   valid/ready  data: samples per group (always ready)
//
// One item at a time. A non-final sample runs six coefficient products
// through the shared split multiplier before the next ready. A group's final
// sample computes the six result components; in one-sample mode the cone and
// scull terms come first, each term ending in a four-step divide by three.
// Reset clears all sums.
// A result held on out_ch stalls the next final sample before its results.
// ----------------------------------------------------------------------------
module coning_sculling_compensation
  import csc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input logic    clk_i,
  input logic    rst_ni,
  csc_in_if.sink   in_ch,
  csc_out_if.source out_ch,
  csc_cfg_if.sink  cfg_ch
);
  csc_cmd_t  cmd;
  csc_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  // Sequencer
  csc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  csc_datapath #(
    .SW(SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .gyro_x_i (in_ch.gyro_x),
    .gyro_y_i (in_ch.gyro_y),
    .gyro_z_i (in_ch.gyro_z),
    .vel_x_i  (in_ch.vel_x),
    .vel_y_i  (in_ch.vel_y),
    .vel_z_i  (in_ch.vel_z),
    .rot_x_o  (out_ch.rot_x),
    .rot_y_o  (out_ch.rot_y),
    .rot_z_o  (out_ch.rot_z),
    .dv_x_o   (out_ch.dv_x),
    .dv_y_o   (out_ch.dv_y),
    .dv_z_o   (out_ch.dv_z)
  );

endmodule
